// File: hw/rtl/fbcp_pkg.sv
package fbcp_pkg;

   // Block geometry
   localparam int BLOCK_BYTES = 8;
   localparam int BLOCK_W     = 8 * BLOCK_BYTES;
   localparam int WORD_W      = BLOCK_W / 2;
   localparam int COUNT_W     = 4;
   localparam int ROUNDS      = 8;

   // Register file: one 64-bit register at byte offset 8*index
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic REG_ROUND_KEYS = 1'b0;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [7:0]         byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Operation codes
   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   localparam count_type COUNT_FULL = count_type'(BLOCK_BYTES);
   localparam block_type PAD_BLOCK  = {BLOCK_BYTES{8'h08}};

   // Rotate every byte left by one and mix in the round key byte
   function automatic word_type round_fn(word_type w, byte_type kb);
      word_type res;
      for (int j = 0; j < WORD_W / 8; j++) begin
         res[8*j +: 8] = {w[8*j +: 7], w[8*j+7]} ^ kb;
      end
      return res;
   endfunction

   // Rounds 0 to 7
   function automatic block_type enc_block(block_type b, block_type keys);
      word_type l;
      word_type r;
      word_type nr;
      l = b[WORD_W-1:0];
      r = b[BLOCK_W-1:WORD_W];
      for (int i = 0; i < ROUNDS; i++) begin
         nr = l ^ round_fn(r, keys[8*i +: 8]);
         l  = r;
         r  = nr;
      end
      return {r, l};
   endfunction

   // Rounds 7 down to 0
   function automatic block_type dec_block(block_type b, block_type keys);
      word_type l;
      word_type r;
      word_type nl;
      l = b[WORD_W-1:0];
      r = b[BLOCK_W-1:WORD_W];
      for (int i = ROUNDS - 1; i >= 0; i--) begin
         nl = r ^ round_fn(l, keys[8*i +: 8]);
         r  = l;
         l  = nl;
      end
      return {r, l};
   endfunction

endpackage

// File: hw/rtl/feistel_block_cipher_pkcs7_unit.sv
// 64-bit, 8-round Feistel cipher with PKCS#7 padding, one 8-byte block per beat.
// A request beat lands in an input register; the rounds, padding check and
// result formatting run as combinational logic from there into the response
// register, so the unit takes a new beat every cycle while the response side
// does not stall. The one exception is a full final block on encrypt, which
// yields two response beats (data, then a whole padding block) and holds the
// input register until the padding beat has moved on. Empty non-final beats
// and an empty message are absorbed with no response. The round key register
// may only be rewritten while no beat is in flight.
module feistel_block_cipher_pkcs7_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [fbcp_pkg::BLOCK_W-1:0] req_in_block,
   input  logic [fbcp_pkg::COUNT_W-1:0] req_in_count,
   input  logic                         req_in_last,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fbcp_pkg::BLOCK_W-1:0] rsp_out_block,
   output logic [fbcp_pkg::COUNT_W-1:0] rsp_out_count,
   output logic                         rsp_out_last,
   output logic                         rsp_status,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fbcp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fbcp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fbcp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import fbcp_pkg::*;

   // register file
   block_type keys_ff;
   block_type keys_in;
   logic      csr_write;

   // message tracking
   logic open_ff;
   logic open_in;

   // input stage
   logic      s1_valid_ff, s1_valid_in;
   op_type    s1_op_ff, s1_op_in;
   block_type s1_block_ff, s1_block_in;
   logic      s1_last_ff, s1_last_in;
   logic      s1_error_ff, s1_error_in;
   logic      s1_two_ff, s1_two_in;
   logic      s1_second_ff, s1_second_in;

   // response stage
   logic      rsp_valid_ff, rsp_valid_in;
   block_type rsp_block_ff, rsp_block_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_status_ff, rsp_status_in;

   // handshake terms
   logic      req_accept;
   logic      req_drop;
   logic      out_free;
   logic      s1_fire;
   logic      s1_done;

   // request decode
   op_type    req_op_dec;
   count_type sat_count;
   byte_type  pad_byte;
   block_type prep_block;

   // cipher and padding check
   block_type cipher_in;
   block_type enc_out;
   block_type dec_out;
   byte_type  pad_len;
   logic      pad_ok;
   count_type dec_count;

   // Register port: writes decode on the register index bit only
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[3] == REG_ROUND_KEYS) ? keys_ff : '0;

   always_comb begin
      keys_in = keys_ff;
      if (csr_write && paddr[3] == REG_ROUND_KEYS) begin
         keys_in = pwdata;
      end
   end

   // Handshake: the input register frees when its last result moves on
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign s1_done    = s1_fire && !(s1_two_ff && !s1_second_ff);
   assign req_stall  = s1_valid_ff && !s1_done;
   assign req_accept = req_valid && !req_stall;

   // Drop empty beats that are not final, and an empty message
   assign req_drop = (req_in_count == '0) && (!req_in_last || !open_ff);

   // Prepare the block on the way in: zero fill or PKCS#7 pad on encrypt
   always_comb begin
      req_op_dec = op_type'(req_op);
      sat_count  = (req_in_count > COUNT_FULL) ? COUNT_FULL : req_in_count;
      pad_byte   = byte_type'(COUNT_FULL - sat_count);
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (count_type'(i) < sat_count) begin
            prep_block[8*i +: 8] = req_in_block[8*i +: 8];
         end else begin
            prep_block[8*i +: 8] = req_in_last ? pad_byte : 8'h00;
         end
      end
   end

   // Input stage next state
   always_comb begin
      open_in      = open_ff;
      s1_valid_in  = s1_valid_ff && !s1_done;
      s1_op_in     = s1_op_ff;
      s1_block_in  = s1_block_ff;
      s1_last_in   = s1_last_ff;
      s1_error_in  = s1_error_ff;
      s1_two_in    = s1_two_ff;
      s1_second_in = s1_second_ff;
      // advance to the padding beat of a two-result item
      if (s1_fire && !s1_done) begin
         s1_second_in = 1'b1;
      end
      if (req_accept && !req_drop) begin
         open_in      = !req_in_last;
         s1_valid_in  = 1'b1;
         s1_op_in     = req_op_dec;
         s1_last_in   = req_in_last;
         s1_second_in = 1'b0;
         unique case (req_op_dec)
            OP_ENCRYPT: begin
               s1_block_in = prep_block;
               s1_error_in = 1'b0;
               s1_two_in   = req_in_last && (sat_count == COUNT_FULL);
            end
            OP_DECRYPT: begin
               s1_block_in = req_in_block;
               s1_error_in = (req_in_count != COUNT_FULL);
               s1_two_in   = 1'b0;
            end
            default: begin
               s1_block_in = req_in_block;
               s1_error_in = 1'b0;
               s1_two_in   = 1'b0;
            end
         endcase
      end
   end

   // Run the rounds from the input register
   assign cipher_in = s1_second_ff ? PAD_BLOCK : s1_block_ff;
   assign enc_out   = enc_block(cipher_in, keys_ff);
   assign dec_out   = dec_block(s1_block_ff, keys_ff);

   // Check the padding of a decrypted final block
   always_comb begin
      pad_len = dec_out[BLOCK_W-1 -: 8];
      pad_ok  = (pad_len >= 8'd1) && (pad_len <= 8'(BLOCK_BYTES));
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (8'(i) >= 8'(BLOCK_BYTES) - pad_len && dec_out[8*i +: 8] != pad_len) begin
            pad_ok = 1'b0;
         end
      end
      dec_count = (s1_last_ff && pad_ok) ? COUNT_FULL - count_type'(pad_len) : COUNT_FULL;
   end

   // Response stage next state
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_block_in  = rsp_block_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         unique case (s1_op_ff)
            OP_ENCRYPT: begin
               rsp_block_in  = enc_out;
               rsp_count_in  = COUNT_FULL;
               rsp_last_in   = s1_last_ff && !(s1_two_ff && !s1_second_ff);
               rsp_status_in = STATUS_OK;
            end
            OP_DECRYPT: begin
               rsp_last_in = s1_last_ff;
               if (s1_error_ff) begin
                  rsp_block_in  = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = STATUS_SHORT;
               end else begin
                  rsp_block_in  = dec_out;
                  rsp_count_in  = dec_count;
                  rsp_status_in = STATUS_OK;
               end
            end
            default: begin
               rsp_block_in  = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff      <= '0;
         open_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keys_ff      <= keys_in;
         open_ff      <= open_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_op_ff      <= s1_op_in;
      s1_block_ff   <= s1_block_in;
      s1_last_ff    <= s1_last_in;
      s1_error_ff   <= s1_error_in;
      s1_two_ff     <= s1_two_in;
      s1_second_ff  <= s1_second_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_block = rsp_block_ff;
   assign rsp_out_count = rsp_count_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
